[rtl/mfh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfh_pkg
// Shared sizes, codes and types for the mutex hand-off unit.
// ----------------------------------------------------------------------------
package mfh_pkg;

	// Bank geometry
	localparam int NUM_MUTEXES = 3;
	localparam int WAIT_DEPTH  = 16;

	// Field widths fixed by the request and response formats
	localparam int ACTION_W = 1;
	localparam int MID_W    = 2;
	localparam int PID_W    = 8;
	localparam int STATUS_W = 3;

	// Derived widths
	localparam int MIDX_W   = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;
	localparam int PTR_W    = $clog2(WAIT_DEPTH);
	localparam int COUNT_W  = $clog2(WAIT_DEPTH + 1);
	localparam int RAM_DEPTH = NUM_MUTEXES * WAIT_DEPTH;
	localparam int RAM_AW    = $clog2(RAM_DEPTH);

	typedef enum logic [ACTION_W-1:0] {
		ACT_WAIT   = 1'b0,
		ACT_SIGNAL = 1'b1
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_ACQUIRED      = 3'd0,
		ST_BLOCKED       = 3'd1,
		ST_RELEASED      = 3'd2,
		ST_TO_RUNNING    = 3'd3,
		ST_TO_READY      = 3'd4,
		ST_WARN_UNLOCKED = 3'd5,
		ST_QUEUE_FULL    = 3'd6
	} status_t;

	// Flat wait-queue address of one slot of one mutex
	function automatic logic [RAM_AW-1:0] slot_addr(input logic [MIDX_W-1:0] idx,
			input logic [PTR_W-1:0] ptr);
		return RAM_AW'(idx) * RAM_AW'(WAIT_DEPTH) + RAM_AW'(ptr);
	endfunction

	// Ring pointer advance with wrap at the queue depth
	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] ptr);
		return (ptr == PTR_W'(WAIT_DEPTH - 1)) ? '0 : ptr + 1'b1;
	endfunction

endpackage

[rtl/mutex_fifo_handoff_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mutex_fifo_handoff_unit
// Bank of hardware mutexes, each with an owner pid and a FIFO of waiting pids.
// Acquire locks or queues the caller; release unlocks or hands the lock to
// the head waiter.
// ----------------------------------------------------------------------------
//
//   channel   handshake              payload
//   -------   --------------------   ------------------------------------------
//   request   req_valid / req_stall  action, mutex_id, proc_id, cpu_idle
//   response  rsp_valid / rsp_stall  status, handoff_pid, cpu_freed, owner_pid
//
// One request per cycle while the response is not stalled; a response goes
// from the taken request through stage 1 (wait-queue read) to the response
// register. The registered wait-queue RAM read is why stage 1 is needed.
// Reset clears all locks, owners and queue pointers at once; the queue RAM
// itself is never cleared, since a slot is only read after it is written.
// A stalled response holds in the response register while stage 1 still
// takes one more request; only then does req_stall rise.
// ----------------------------------------------------------------------------
module mutex_fifo_handoff_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	// request channel
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic [mfh_pkg::ACTION_W-1:0] action,
	input  logic [mfh_pkg::MID_W-1:0]    mutex_id,
	input  logic [mfh_pkg::PID_W-1:0]    proc_id,
	input  logic                         cpu_idle,
	// response channel
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic [mfh_pkg::STATUS_W-1:0] status,
	output logic [mfh_pkg::PID_W-1:0]    handoff_pid,
	output logic                         cpu_freed,
	output logic [mfh_pkg::PID_W-1:0]    owner_pid
);

	import mfh_pkg::*;

	// Per-mutex control state (small, kept in flops so reset clears it)
	logic                lock_q  [NUM_MUTEXES];
	logic [PID_W-1:0]    owner_q [NUM_MUTEXES];
	logic [PTR_W-1:0]    head_q  [NUM_MUTEXES];
	logic [PTR_W-1:0]    tail_q  [NUM_MUTEXES];
	logic [COUNT_W-1:0]  count_q [NUM_MUTEXES];

	// Stage 1: decision made, waiting for the wait-queue read data
	logic                valid_s1;
	status_t             status_s1;
	logic                handoff_s1;
	logic                freed_s1;
	logic [PID_W-1:0]    owner_s1;
	logic [MIDX_W-1:0]   midx_s1;
	// Owner write-back of a hand-off is due on the first cycle of stage 1
	logic                owner_wb_q;

	// Response register
	logic                rsp_valid_q;
	status_t             status_q;
	logic [PID_W-1:0]    handoff_pid_q;
	logic                cpu_freed_q;
	logic [PID_W-1:0]    owner_pid_q;

	// Wait-queue RAM ports
	logic                ram_wr_en;
	logic [RAM_AW-1:0]   ram_wr_addr;
	logic                ram_rd_en;
	logic [RAM_AW-1:0]   ram_rd_addr;
	logic [PID_W-1:0]    ram_rd_data;

	// Handshake
	logic                req_take;
	logic                rsp_free;
	logic                s1_move;

	// Request decode
	logic                in_range;
	logic [MIDX_W-1:0]   midx;
	logic                cur_lock;
	logic [PID_W-1:0]    cur_owner;
	logic [PTR_W-1:0]    cur_head;
	logic [PTR_W-1:0]    cur_tail;
	logic [COUNT_W-1:0]  cur_count;
	logic                q_full;
	logic                q_empty;

	// Next values for the addressed mutex
	status_t             dec_status;
	logic                dec_handoff;
	logic                dec_freed;
	logic [PID_W-1:0]    dec_owner_out;
	logic                upd_lock;
	logic                nxt_lock;
	logic                upd_owner;
	logic [PID_W-1:0]    nxt_owner;
	logic                push;
	logic                pop;

	// ---------------------------------------------------------------- handshake
	// Stage 1 drains into the response register whenever that register is
	// empty or being emptied; a new request enters whenever stage 1 frees up.
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign s1_move   = valid_s1 && rsp_free;
	assign req_stall = valid_s1 && !rsp_free;
	assign req_take  = req_valid && !req_stall;

	// ---------------------------------------------------------------- lookup
	assign in_range = (int'(mutex_id) < NUM_MUTEXES);
	assign midx     = MIDX_W'(mutex_id);

	always_comb begin
		cur_lock  = lock_q[midx];
		cur_head  = head_q[midx];
		cur_tail  = tail_q[midx];
		cur_count = count_q[midx];
		// Forward a hand-off owner that lands in the queue read data this cycle
		if (owner_wb_q && (midx_s1 == midx)) begin
			cur_owner = ram_rd_data;
		end else begin
			cur_owner = owner_q[midx];
		end
	end

	assign q_full  = (cur_count == COUNT_W'(WAIT_DEPTH));
	assign q_empty = (cur_count == '0);

	// ---------------------------------------------------------------- decision
	always_comb begin
		dec_status    = ST_WARN_UNLOCKED;
		dec_handoff   = 1'b0;
		dec_freed     = 1'b0;
		dec_owner_out = '0;
		upd_lock      = 1'b0;
		nxt_lock      = 1'b0;
		upd_owner     = 1'b0;
		nxt_owner     = '0;
		push          = 1'b0;
		pop           = 1'b0;
		if (in_range) begin
			if (action == ACT_WAIT) begin
				if (!cur_lock) begin
					// free: lock for the caller
					dec_status    = ST_ACQUIRED;
					upd_lock      = 1'b1;
					nxt_lock      = 1'b1;
					upd_owner     = 1'b1;
					nxt_owner     = proc_id;
					dec_owner_out = proc_id;
				end else if (q_full) begin
					// drop the caller, report full
					dec_status    = ST_QUEUE_FULL;
					dec_owner_out = cur_owner;
				end else begin
					// enqueue the caller at the tail
					dec_status    = ST_BLOCKED;
					dec_freed     = 1'b1;
					push          = 1'b1;
					dec_owner_out = cur_owner;
				end
			end else begin
				if (!cur_lock) begin
					dec_status = ST_WARN_UNLOCKED;
				end else if (q_empty) begin
					// no waiters: unlock
					dec_status = ST_RELEASED;
					upd_lock   = 1'b1;
					nxt_lock   = 1'b0;
					upd_owner  = 1'b1;
					nxt_owner  = '0;
				end else begin
					// hand off to the head waiter; its pid arrives next cycle
					dec_status  = cpu_idle ? ST_TO_RUNNING : ST_TO_READY;
					dec_handoff = 1'b1;
					pop         = 1'b1;
				end
			end
		end
	end

	// ---------------------------------------------------------------- wait queue
	assign ram_wr_en   = req_take && push;
	assign ram_wr_addr = slot_addr(midx, cur_tail);
	assign ram_rd_en   = req_take && pop;
	assign ram_rd_addr = slot_addr(midx, cur_head);

	mfh_ram #(
		.WIDTH (PID_W),
		.DEPTH (RAM_DEPTH)
	) u_wait_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (proc_id),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// ---------------------------------------------------------------- control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_MUTEXES; i++) begin
				lock_q[i]  <= 1'b0;
				owner_q[i] <= '0;
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
			owner_wb_q <= 1'b0;
		end else begin
			// Land the hand-off owner unless a newer request rewrites that mutex
			for (int i = 0; i < NUM_MUTEXES; i++) begin
				if (req_take && upd_owner && (midx == MIDX_W'(i))) begin
					owner_q[i] <= nxt_owner;
				end else if (owner_wb_q && (midx_s1 == MIDX_W'(i))) begin
					owner_q[i] <= ram_rd_data;
				end
			end
			owner_wb_q <= req_take && pop;
			if (req_take) begin
				if (upd_lock) begin
					lock_q[midx] <= nxt_lock;
				end
				if (push) begin
					tail_q[midx]  <= next_slot(cur_tail);
					count_q[midx] <= cur_count + 1'b1;
				end
				if (pop) begin
					head_q[midx]  <= next_slot(cur_head);
					count_q[midx] <= cur_count - 1'b1;
				end
			end
		end
	end

	// ---------------------------------------------------------------- stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			status_s1  <= dec_status;
			handoff_s1 <= dec_handoff;
			freed_s1   <= dec_freed;
			owner_s1   <= dec_owner_out;
			midx_s1    <= midx;
		end
	end

	// ---------------------------------------------------------------- response
	// RAM read data holds while stage 1 waits, since no new read is issued.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_free) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			status_q      <= status_s1;
			handoff_pid_q <= handoff_s1 ? ram_rd_data : '0;
			cpu_freed_q   <= freed_s1;
			owner_pid_q   <= handoff_s1 ? ram_rd_data : owner_s1;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign handoff_pid = handoff_pid_q;
	assign cpu_freed   = cpu_freed_q;
	assign owner_pid   = owner_pid_q;

`ifndef SYNTH
	for (genvar g = 0; g < NUM_MUTEXES; g++) begin : g_chk
		// queue occupancy never exceeds its depth
		a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
			count_q[g] <= COUNT_W'(WAIT_DEPTH))
			else $error("wait queue %0d over depth", g);
		// waiters exist only behind a held lock
		a_wait_locked: assert property (@(posedge clk) disable iff (!arst_n)
			(count_q[g] != '0) |-> lock_q[g])
			else $error("waiters on unlocked mutex %0d", g);
	end

	a_freed_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (cpu_freed_q == (status_q == ST_BLOCKED)))
		else $error("cpu_freed does not match blocked status");

	a_handoff_pid: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (status_q != ST_TO_RUNNING) && (status_q != ST_TO_READY))
			|-> (handoff_pid_q == '0))
		else $error("hand-off pid without a hand-off");
`endif

endmodule

[rtl/mfh_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfh_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mfh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[bench/mutex_fifo_handoff_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mutex_fifo_handoff_unit_tb
// Drives acquire and release requests into the mutex bank and compares each
// response with a scoreboard that keeps its own locks, owners and wait queues.
// Directed cases come first: every status, pid zero, an out-of-range mutex and
// a full wait queue. Random traffic follows, in phases that favor filling or
// draining the queues, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module mutex_fifo_handoff_unit_tb;
	import mfh_pkg::*;

	// A stretch this long with no transaction on either channel means a hang.
	localparam int STUCK_LIMIT = 2000;
	// Extra cycles to watch at the end for stray responses.
	localparam int TAIL_CYCLES = 8;
	localparam int REPORT_MAX  = 10;
	// The id field reaches one past the last mutex.
	localparam logic [MID_W-1:0] MID_OUT_OF_RANGE = MID_W'(NUM_MUTEXES);

	typedef struct packed {
		status_t          status;
		logic [PID_W-1:0] handoff;
		logic             freed;
		logic [PID_W-1:0] owner;
	} mutex_result_t;

	// Sender and receiver idling: normal mix, none at all, or heavy.
	typedef enum {FLOW_NORMAL, FLOW_STEADY, FLOW_CHOKED} flow_mode_t;

	logic                  clk;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_stall;
	logic [ACTION_W-1:0]   action;
	logic [MID_W-1:0]      mutex_id;
	logic [PID_W-1:0]      proc_id;
	logic                  cpu_idle;
	logic                  rsp_valid;
	logic                  rsp_stall;
	logic [STATUS_W-1:0]   status;
	logic [PID_W-1:0]      handoff_pid;
	logic                  cpu_freed;
	logic [PID_W-1:0]      owner_pid;

	// Scoreboard copy of the bank
	logic                  mx_locked [NUM_MUTEXES];
	logic [PID_W-1:0]      mx_owner  [NUM_MUTEXES];
	logic [PID_W-1:0]      wq_slots  [NUM_MUTEXES][WAIT_DEPTH];
	int                    wq_head   [NUM_MUTEXES];
	int                    wq_count  [NUM_MUTEXES];

	mutex_result_t         pending_results[$];
	flow_mode_t            flow;
	int                    stall_left;
	int                    stuck_cycles;
	int                    fail_count;
	int                    sent_count;
	int                    checked_count;
	int                    status_seen [7];

	mutex_fifo_handoff_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.action      (action),
		.mutex_id    (mutex_id),
		.proc_id     (proc_id),
		.cpu_idle    (cpu_idle),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.handoff_pid (handoff_pid),
		.cpu_freed   (cpu_freed),
		.owner_pid   (owner_pid)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Pick an idle length: mostly none, some short, a few long.
	function automatic int pick_gap();
		int roll;
		if (flow == FLOW_STEADY)
			return 0;
		roll = (flow == FLOW_CHOKED) ? $urandom_range(40, 99) : $urandom_range(0, 99);
		if (roll < 65)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// Apply one request to the scoreboard bank and return the response it earns.
	function automatic mutex_result_t resolve_request(input action_t act,
			input logic [MID_W-1:0] mid, input logic [PID_W-1:0] pid, input logic idle);
		mutex_result_t r;
		int m;
		r.status  = ST_WARN_UNLOCKED;
		r.handoff = '0;
		r.freed   = 1'b0;
		r.owner   = '0;
		// An id past the bank touches nothing and reports a warning.
		if (mid >= NUM_MUTEXES)
			return r;
		m = mid;
		if (act == ACT_WAIT) begin
			if (!mx_locked[m]) begin
				mx_locked[m] = 1'b1;
				mx_owner[m]  = pid;
				r.status     = ST_ACQUIRED;
			end else if (wq_count[m] >= WAIT_DEPTH) begin
				r.status = ST_QUEUE_FULL;
			end else begin
				wq_slots[m][(wq_head[m] + wq_count[m]) % WAIT_DEPTH] = pid;
				wq_count[m]++;
				r.status = ST_BLOCKED;
				r.freed  = 1'b1;
			end
		end else begin
			if (!mx_locked[m]) begin
				r.status = ST_WARN_UNLOCKED;
			end else if (wq_count[m] == 0) begin
				mx_locked[m] = 1'b0;
				mx_owner[m]  = '0;
				r.status     = ST_RELEASED;
			end else begin
				// Hand the lock straight to the head waiter.
				r.handoff   = wq_slots[m][wq_head[m]];
				wq_head[m]  = (wq_head[m] + 1) % WAIT_DEPTH;
				wq_count[m]--;
				mx_owner[m] = r.handoff;
				r.status    = idle ? ST_TO_RUNNING : ST_TO_READY;
			end
		end
		r.owner = mx_locked[m] ? mx_owner[m] : '0;
		return r;
	endfunction

	// Present one request, hold it until taken, then book its response.
	task automatic send_request(input action_t act, input logic [MID_W-1:0] mid,
			input logic [PID_W-1:0] pid, input logic idle);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		action    <= act;
		mutex_id  <= mid;
		proc_id   <= pid;
		cpu_idle  <= idle;
		do
			@(posedge clk);
		while (req_stall);
		pending_results.push_back(resolve_request(act, mid, pid, idle));
		sent_count++;
	endtask

	// Hold the request channel idle until every booked response is back.
	// A clock edge always passes first, so valid never drops and rises in one step.
	task automatic wait_for_results();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	task automatic random_requests(input int count, input int wait_pct);
		action_t          act;
		logic [MID_W-1:0] mid;
		logic [PID_W-1:0] pid;
		for (int i = 0; i < count; i++) begin
			act = ($urandom_range(0, 99) < wait_pct) ? ACT_WAIT : ACT_SIGNAL;
			mid = ($urandom_range(0, 99) < 8) ? MID_OUT_OF_RANGE
				: MID_W'($urandom_range(0, NUM_MUTEXES - 1));
			pid = ($urandom_range(0, 19) == 0) ? '0 : PID_W'($urandom_range(1, 255));
			send_request(act, mid, pid, 1'($urandom_range(0, 1)));
			// Now and then let the bank go completely quiet.
			if ($urandom_range(0, 149) == 0)
				wait_for_results();
		end
	endtask

	// Every status but queue full: plain lock and unlock, warnings, pid zero as owner,
	// hand-off to running and to ready, and release by a caller that is not
	// the owner.
	task automatic test_basic_ops();
		flow = FLOW_NORMAL;
		send_request(ACT_WAIT,   2'd0, 8'hFF, 1'b1);
		send_request(ACT_WAIT,   MID_OUT_OF_RANGE, 8'hAA, 1'b1);
		send_request(ACT_SIGNAL, MID_OUT_OF_RANGE, 8'h55, 1'b0);
		send_request(ACT_SIGNAL, 2'd0, 8'h07, 1'b0);
		send_request(ACT_SIGNAL, 2'd0, 8'hFF, 1'b1);
		send_request(ACT_WAIT,   2'd1, 8'h00, 1'b0);
		send_request(ACT_WAIT,   2'd1, 8'h01, 1'b1);
		send_request(ACT_WAIT,   2'd1, 8'h80, 1'b0);
		send_request(ACT_SIGNAL, 2'd1, 8'h00, 1'b1);
		send_request(ACT_SIGNAL, 2'd1, 8'h01, 1'b0);
		send_request(ACT_SIGNAL, 2'd1, 8'h80, 1'b0);
		send_request(ACT_WAIT,   2'd2, 8'h5A, 1'b0);
		send_request(ACT_WAIT,   2'd2, 8'hA5, 1'b1);
		send_request(ACT_SIGNAL, 2'd2, 8'h33, 1'b1);
		send_request(ACT_SIGNAL, 2'd2, 8'hA5, 1'b0);
	endtask

	// Fill one wait queue to the brim, push past it, then drain it in order.
	task automatic test_queue_full();
		flow = FLOW_NORMAL;
		send_request(ACT_WAIT, 2'd2, 8'd200, 1'b0);
		for (int i = 0; i < WAIT_DEPTH + 2; i++)
			send_request(ACT_WAIT, 2'd2, PID_W'(i + 1), 1'($urandom_range(0, 1)));
		for (int i = 0; i < WAIT_DEPTH + 1; i++)
			send_request(ACT_SIGNAL, 2'd2, PID_W'($urandom), 1'($urandom_range(0, 1)));
	endtask

	// Balanced mix under the normal idle pattern.
	task automatic test_mixed_traffic();
		flow = FLOW_NORMAL;
		random_requests(500, 50);
	endtask

	// Acquire-heavy: queues grow, wrap and overflow.
	task automatic test_contention();
		flow = FLOW_NORMAL;
		random_requests(300, 72);
	endtask

	// Release-heavy under long gaps and stalls: queues empty out again.
	task automatic test_release_storm();
		flow = FLOW_CHOKED;
		random_requests(300, 35);
	endtask

	// Let the pipeline run dry, then restart from a quiet bank.
	task automatic test_drain_pause();
		flow = FLOW_NORMAL;
		random_requests(20, 60);
		wait_for_results();
		random_requests(20, 40);
	endtask

	// One request per cycle, apart from the odd quiet pause; receiver never stalls.
	task automatic test_back_to_back();
		flow = FLOW_STEADY;
		random_requests(360, 55);
	endtask

	task automatic note_failure();
		fail_count++;
	endtask

	// Response side: check every transaction against the oldest booked result,
	// then choose the stall for the next cycle.
	always @(posedge clk) begin
		mutex_result_t exp_r;
		int            new_stall;
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				stuck_cycles <= 0;
			else
				stuck_cycles <= stuck_cycles + 1;

			if (rsp_valid && !rsp_stall) begin
				if (pending_results.size() == 0) begin
					note_failure();
					if (fail_count <= REPORT_MAX)
						$display("mismatch %0d at %0t: response with no request outstanding",
							fail_count, $time);
				end else begin
					exp_r = pending_results.pop_front();
					checked_count++;
					status_seen[exp_r.status]++;
					if (status !== exp_r.status || handoff_pid !== exp_r.handoff
							|| cpu_freed !== exp_r.freed || owner_pid !== exp_r.owner) begin
						note_failure();
						if (fail_count <= REPORT_MAX)
							$display({"mismatch %0d at %0t: expected status %0d handoff %0d ",
								"freed %0d owner %0d, got status %0d handoff %0d freed %0d ",
								"owner %0d"}, fail_count, $time, exp_r.status, exp_r.handoff,
								exp_r.freed, exp_r.owner, status, handoff_pid, cpu_freed,
								owner_pid);
					end
				end
			end

			// Hold a running stall, or start a new one of random length.
			if (stall_left > 0) begin
				rsp_stall  <= 1'b1;
				stall_left <= stall_left - 1;
			end else begin
				new_stall = pick_gap();
				rsp_stall <= (new_stall > 0);
				stall_left <= (new_stall > 0) ? new_stall - 1 : 0;
			end
		end
	end

	// Drop out if neither channel moves for too long.
	initial begin
		wait (stuck_cycles >= STUCK_LIMIT);
		$display("hang: no transaction for %0d cycles, %0d responses outstanding",
			STUCK_LIMIT, pending_results.size());
		$display("tb: failure");
		$finish;
	end

	initial begin
		flow          = FLOW_NORMAL;
		stall_left    <= 0;
		stuck_cycles  <= 0;
		fail_count    = 0;
		sent_count    = 0;
		checked_count = 0;
		foreach (status_seen[i])
			status_seen[i] = 0;
		for (int m = 0; m < NUM_MUTEXES; m++) begin
			mx_locked[m] = 1'b0;
			mx_owner[m]  = '0;
			wq_head[m]   = 0;
			wq_count[m]  = 0;
		end
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		action    <= ACT_WAIT;
		mutex_id  <= '0;
		proc_id   <= '0;
		cpu_idle  <= 1'b0;
		rsp_stall <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_ops();
		test_queue_full();
		test_mixed_traffic();
		test_contention();
		test_drain_pause();
		test_release_storm();
		test_back_to_back();

		// Let the last responses out, then watch a little longer for strays.
		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("summary: %0d requests sent, %0d responses checked, %0d failures",
			sent_count, checked_count, fail_count);
		$display({"summary: acquired %0d, blocked %0d, released %0d, to running %0d, ",
			"to ready %0d, warnings %0d, queue full %0d"}, status_seen[ST_ACQUIRED],
			status_seen[ST_BLOCKED], status_seen[ST_RELEASED], status_seen[ST_TO_RUNNING],
			status_seen[ST_TO_READY], status_seen[ST_WARN_UNLOCKED],
			status_seen[ST_QUEUE_FULL]);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
